FILE: design/fmps_pkg.sv
// fmps_pkg: shared constants, types and helpers for the price path step.
// Used by fmps_mul and factor_model_price_path_step; no dependencies.
package fmps_pkg;

    localparam int FRAC_BITS = 40;
    localparam int VAL_W     = 48;
    localparam int MAG_W     = VAL_W + 1;
    localparam int SUM_W     = VAL_W + 4;
    localparam int EXP_FRAC  = 56;
    localparam int MUL_AW    = EXP_FRAC + 1;
    localparam int MUL_CW    = 19;
    localparam int MUL_NCH   = 3;
    localparam int PROD_W    = 2 * MUL_AW;
    localparam int CFG_W     = 46;
    localparam int RAD_W     = VAL_W + FRAC_BITS;
    localparam int ROOT_W    = RAD_W / 2;
    localparam int SQRT_REM_W = ROOT_W + 3;
    localparam int XR_W      = 61;
    localparam int QUO_W     = 60;
    localparam int QUO_STEPS = QUO_W / 4;
    localparam int N_TERMS   = 24;

    localparam logic [63:0] W_INNOV_64   = ((64'd5 << FRAC_BITS) + 64'd50) / 64'd100;
    localparam logic [63:0] W_PERSIST_64 = ((64'd85 << FRAC_BITS) + 64'd50) / 64'd100;
    localparam logic [63:0] W_OMEGA_64   =
        ((64'd169 << FRAC_BITS) + 64'd5000000) / 64'd10000000;
    localparam logic [63:0] START_VAR_64 =
        ((64'd169 << FRAC_BITS) + 64'd500000) / 64'd1000000;

    localparam logic signed [VAL_W-1:0] W_INNOV   = W_INNOV_64[VAL_W-1:0];
    localparam logic signed [VAL_W-1:0] W_PERSIST = W_PERSIST_64[VAL_W-1:0];
    localparam logic signed [VAL_W-1:0] W_OMEGA   = W_OMEGA_64[VAL_W-1:0];
    localparam logic signed [VAL_W-1:0] START_VAR = START_VAR_64[VAL_W-1:0];

    localparam logic signed [VAL_W-1:0] MAX48 = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] MIN48 = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] EXP_HI = VAL_W'(64'd22 << FRAC_BITS);

    localparam logic [EXP_FRAC-1:0] LN2_E = 56'hB17217F7D1CF7A;
    localparam logic [30:0] PRICE_MAX = 31'h7FFFFFFF;

    localparam logic [2:0] REG_MKT_LOAD = 3'd0;
    localparam logic [2:0] REG_SEC_LOAD = 3'd1;
    localparam logic [2:0] REG_REV_SPD  = 3'd2;
    localparam logic [2:0] REG_GROWTH   = 3'd3;
    localparam logic [2:0] REG_START_LP = 3'd4;

    localparam logic [42:0] RST_MKT_LOAD = 43'd1099511627776;
    localparam logic [42:0] RST_SEC_LOAD = 43'd1099511627776;
    localparam logic [40:0] RST_REV_SPD  = 41'd13194139533;
    localparam logic signed [38:0] RST_GROWTH = 39'sd219902326;
    localparam logic [CFG_W-1:0] RST_START_LP = 46'd7595157000000;

    typedef struct packed {
        logic                    path_start;
        logic signed [VAL_W-1:0] mkt_return;
        logic signed [VAL_W-1:0] sector_return;
        logic signed [VAL_W-1:0] fundamental_noise;
        logic signed [VAL_W-1:0] unit_t_draw;
    } in_word_t;

    typedef struct packed {
        logic [30:0]             price;
        logic signed [VAL_W-1:0] log_price_out;
    } out_word_t;

    typedef struct packed {
        logic              start;
        logic [MUL_AW-1:0] a;
        logic [MUL_AW-1:0] b;
    } mul_req_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PREP, ST_MSTART, ST_MWAIT, ST_MRND, ST_SQRT,
        ST_EXP, ST_KDIV, ST_TDIV, ST_PFIN, ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        OP_EE, OP_WIN, OP_WPER, OP_INNOV, OP_MKT, OP_SEC, OP_REV, OP_TERM
    } op_t;

    function automatic logic signed [VAL_W-1:0] sat48(input logic signed [SUM_W-1:0] v);
        logic same;
        same = (v[SUM_W-1:VAL_W-1] == {(SUM_W-VAL_W+1){v[SUM_W-1]}});
        if (same)
            return v[VAL_W-1:0];
        else if (v[SUM_W-1])
            return MIN48;
        else
            return MAX48;
    endfunction

    function automatic logic signed [SUM_W-1:0] sx(input logic signed [VAL_W-1:0] v);
        return {{(SUM_W-VAL_W){v[VAL_W-1]}}, v};
    endfunction

    function automatic logic [MAG_W-1:0] mag(input logic signed [MAG_W-1:0] v);
        logic [MAG_W-1:0] n;
        n = MAG_W'(-v);
        return v[MAG_W-1] ? n : v;
    endfunction

endpackage

FILE: design/fmps_mul.sv
// fmps_mul: unsigned multiplier, one 57x19 partial product per cycle.
// Depends on fmps_pkg.
module fmps_mul (
    input  logic                      clk,
    input  logic                      rst_n,
    input  fmps_pkg::mul_req_t        req,
    output logic                      done,
    output logic [fmps_pkg::PROD_W-1:0] prod
);
    import fmps_pkg::*;

    logic [MUL_AW-1:0] a_reg;
    logic [MUL_AW-1:0] b_reg;
    logic [PROD_W-1:0] acc_reg;
    logic [PROD_W-1:0] acc_next;
    logic [1:0]        cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [MUL_CW-1:0] chunk;
    logic [MUL_AW+MUL_CW-1:0] pp;

    assign chunk    = b_reg[cnt_reg*MUL_CW +: MUL_CW];
    assign pp       = a_reg * chunk;
    assign acc_next = {acc_reg[PROD_W-MUL_CW-1:0], {MUL_CW{1'b0}}} + PROD_W'(pp);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 2'(MUL_NCH - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 2'd1;
                if (cnt_reg == 2'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

FILE: design/factor_model_price_path_step.sv
// One step of a GARCH(1,1) three-factor log price path, with exp to price.
// For an in-range price the step runs seven multiplies on one shared multiplier, a square
// root, an ln2 reduction and 24 Taylor terms (a multiply and a divide each); when the
// price floors or saturates, the ln2 reduction and the Taylor terms are skipped.
// One word at a time: a new word is taken after the result leaves.
// Reset (async, active low) loads register defaults and the start path state.
module factor_model_price_path_step (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  fmps_pkg::in_word_t           in_word,
    output logic                         out_valid,
    input  logic                         out_ready,
    output fmps_pkg::out_word_t          out_word,
    input  logic                         cfg_we,
    input  logic [2:0]                   cfg_index,
    input  logic [fmps_pkg::CFG_W-1:0]   cfg_data
);
    import fmps_pkg::*;

    state_t state_reg, state_next;
    op_t    op_reg;

    logic [42:0]             ml_reg, sl_reg;
    logic [40:0]             rs_reg;
    logic signed [38:0]      gt_reg;
    logic [CFG_W-1:0]        slp_reg;

    logic signed [VAL_W-1:0] lp_reg, lf_reg, cv_reg, li_reg;
    logic signed [VAL_W-1:0] mret_reg, sret_reg, noise_reg, tdraw_reg;
    logic signed [MAG_W-1:0] dev_reg;
    logic signed [VAL_W-1:0] growth_reg, tmp_reg, innov_reg;
    logic signed [SUM_W-1:0] acc_reg;
    logic                    neg_reg;

    logic [RAD_W-1:0]        rad_reg;
    logic [SQRT_REM_W-1:0]   srem_reg;
    logic [ROOT_W-1:0]       root_reg;
    logic [5:0]              cnt_reg;

    logic [XR_W-1:0]         xr_reg;
    logic [4:0]              k_reg;
    logic [MUL_AW-1:0]       term_reg;
    logic [MUL_AW:0]         esum_reg;
    logic [4:0]              n_reg;
    logic [QUO_W-1:0]        quo_reg;
    logic [4:0]              drem_reg;

    out_word_t               out_word_reg;
    logic                    out_valid_reg;

    mul_req_t                mreq;
    logic                    mul_done;
    logic [PROD_W-1:0]       mul_prod;

    logic signed [VAL_W-1:0] growth_c;
    logic signed [MAG_W-1:0] opa, opb;
    logic [PROD_W-1:0]       rnd_t, rnd_q;
    logic [VAL_W-1:0]        lim, qs;
    logic signed [VAL_W-1:0] res;

    logic [SQRT_REM_W-1:0]   srem_sh, strial;
    logic [XR_W-1:0]         ktrial;
    logic [QUO_W-1:0]        quo_next;
    logic [4:0]              drem_next;
    logic [5:0]              dr2;
    logic [5:0]              sh;
    logic [MUL_AW+1:0]       pr_wide;
    logic [30:0]             pr_c;

    fmps_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    function automatic logic signed [MAG_W-1:0] sx49(input logic signed [VAL_W-1:0] v);
        return {v[VAL_W-1], v};
    endfunction

    // operand select
    always_comb
    begin
        case (op_reg)
            OP_EE:    begin opa = sx49(li_reg);          opb = sx49(li_reg);    end
            OP_WIN:   begin opa = sx49(W_INNOV);         opb = sx49(tmp_reg);   end
            OP_WPER:  begin opa = sx49(W_PERSIST);       opb = sx49(cv_reg);    end
            OP_INNOV: begin opa = MAG_W'(root_reg);      opb = sx49(tdraw_reg); end
            OP_MKT:   begin opa = MAG_W'(ml_reg);        opb = sx49(mret_reg);  end
            OP_SEC:   begin opa = MAG_W'(sl_reg);        opb = sx49(sret_reg);  end
            OP_REV:   begin opa = MAG_W'(rs_reg);        opb = dev_reg;         end
            default:  begin opa = '0;                    opb = '0;              end
        endcase
    end

    // round, shift, saturate
    always_comb
    begin
        rnd_t = mul_prod + (PROD_W'(1) << (FRAC_BITS - 1));
        rnd_q = rnd_t >> FRAC_BITS;
        lim   = neg_reg ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        qs    = (rnd_q > PROD_W'(lim)) ? lim : rnd_q[VAL_W-1:0];
        res   = neg_reg ? -$signed(qs) : $signed(qs);
    end

    assign growth_c = sat48(sx(VAL_W'(gt_reg)) + sx(noise_reg));

    // square root digit
    always_comb
    begin
        srem_sh = {srem_reg[SQRT_REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
        strial  = {1'b0, root_reg, 2'b01};
    end

    assign ktrial = XR_W'(LN2_E) << cnt_reg[2:0];

    // divide by term index, four bits a cycle
    always_comb
    begin
        quo_next  = quo_reg;
        drem_next = drem_reg;
        dr2       = '0;
        for (int i = 0; i < 4; i++)
        begin
            dr2 = {drem_next, quo_next[QUO_W-1]};
            if (dr2 >= {1'b0, n_reg})
            begin
                drem_next = 5'(dr2 - {1'b0, n_reg});
                quo_next  = {quo_next[QUO_W-2:0], 1'b1};
            end
            else
            begin
                drem_next = dr2[4:0];
                quo_next  = {quo_next[QUO_W-2:0], 1'b0};
            end
        end
    end

    // final price rounding
    always_comb
    begin
        sh      = 6'(EXP_FRAC) - {1'b0, k_reg};
        pr_wide = ((MUL_AW+2)'(esum_reg) + ((MUL_AW+2)'(1) << (sh - 6'd1))) >> sh;
        if (pr_wide > (MUL_AW+2)'(PRICE_MAX))
            pr_c = PRICE_MAX;
        else if (pr_wide == '0)
            pr_c = 31'd1;
        else
            pr_c = pr_wide[30:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_valid && in_ready) state_next = ST_PREP;
            ST_PREP:   state_next = ST_MSTART;
            ST_MSTART: state_next = ST_MWAIT;
            ST_MWAIT:
                if (mul_done)
                    state_next = (op_reg == OP_TERM) ? ST_TDIV : ST_MRND;
            ST_MRND:
                case (op_reg)
                    OP_WPER: state_next = ST_SQRT;
                    OP_REV:  state_next = ST_EXP;
                    default: state_next = ST_MSTART;
                endcase
            ST_SQRT:   if (cnt_reg == '0) state_next = ST_MSTART;
            ST_EXP:
                if (lp_reg <= 0 || lp_reg >= EXP_HI)
                    state_next = ST_DONE;
                else
                    state_next = ST_KDIV;
            ST_KDIV:   if (cnt_reg == '0) state_next = ST_MSTART;
            ST_TDIV:
                if (cnt_reg == '0)
                    state_next = (n_reg == 5'(N_TERMS)) ? ST_PFIN : ST_MSTART;
            ST_PFIN:   state_next = ST_DONE;
            ST_DONE:   if (!out_valid_reg || out_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        in_ready   = (state_reg == ST_IDLE) && !out_valid_reg;
        mreq.start = (state_reg == ST_MSTART);
        if (op_reg == OP_TERM)
        begin
            mreq.a = term_reg;
            mreq.b = xr_reg[MUL_AW-1:0];
        end
        else
        begin
            mreq.a = MUL_AW'(mag(opa));
            mreq.b = MUL_AW'(mag(opb));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_EE;
            out_valid_reg <= 1'b0;
            ml_reg        <= RST_MKT_LOAD;
            sl_reg        <= RST_SEC_LOAD;
            rs_reg        <= RST_REV_SPD;
            gt_reg        <= RST_GROWTH;
            slp_reg       <= RST_START_LP;
            lp_reg        <= VAL_W'(RST_START_LP);
            lf_reg        <= VAL_W'(RST_START_LP);
            cv_reg        <= START_VAR;
            li_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MKT_LOAD: ml_reg  <= cfg_data[42:0];
                    REG_SEC_LOAD: sl_reg  <= cfg_data[42:0];
                    REG_REV_SPD:  rs_reg  <= cfg_data[40:0];
                    REG_GROWTH:   gt_reg  <= cfg_data[38:0];
                    REG_START_LP: slp_reg <= cfg_data;
                    default: ;
                endcase
            end

            case (state_reg)
                ST_IDLE:
                    if (in_valid && in_ready && in_word.path_start)
                    begin
                        lp_reg <= VAL_W'(slp_reg);
                        lf_reg <= VAL_W'(slp_reg);
                        cv_reg <= START_VAR;
                        li_reg <= '0;
                    end
                ST_PREP:
                begin
                    lf_reg <= sat48(sx(lf_reg) + sx(growth_c));
                    op_reg <= OP_EE;
                end
                ST_MRND:
                    case (op_reg)
                        OP_EE:    op_reg <= OP_WIN;
                        OP_WIN:   op_reg <= OP_WPER;
                        OP_WPER:
                        begin
                            cv_reg <= sat48(acc_reg + sx(res));
                            op_reg <= OP_INNOV;
                        end
                        OP_INNOV: op_reg <= OP_MKT;
                        OP_MKT:   op_reg <= OP_SEC;
                        OP_SEC:   op_reg <= OP_REV;
                        OP_REV:
                        begin
                            lp_reg <= sat48(acc_reg - sx(res));
                            li_reg <= innov_reg;
                            op_reg <= OP_TERM;
                        end
                        default: ;
                    endcase
                ST_DONE:
                    if (!out_valid_reg || out_ready)
                        out_valid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (in_valid && in_ready)
                begin
                    mret_reg  <= in_word.mkt_return;
                    sret_reg  <= in_word.sector_return;
                    noise_reg <= in_word.fundamental_noise;
                    tdraw_reg <= in_word.unit_t_draw;
                end
            ST_PREP:
            begin
                dev_reg    <= sx49(lp_reg) - sx49(lf_reg);
                growth_reg <= growth_c;
                acc_reg    <= sx(W_OMEGA);
            end
            ST_MSTART:
                neg_reg <= (op_reg != OP_TERM) && (opa[MAG_W-1] ^ opb[MAG_W-1]);
            ST_MWAIT:
                if (mul_done && op_reg == OP_TERM)
                begin
                    quo_reg  <= QUO_W'(mul_prod[PROD_W-2:EXP_FRAC]);
                    drem_reg <= '0;
                    cnt_reg  <= 6'(QUO_STEPS - 1);
                end
            ST_MRND:
                case (op_reg)
                    OP_EE:    tmp_reg <= res;
                    OP_WIN:   acc_reg <= acc_reg + sx(res);
                    OP_WPER:
                    begin
                        rad_reg  <= {sat48(acc_reg + sx(res)) & {VAL_W{~acc_reg[SUM_W-1]}},
                                     {FRAC_BITS{1'b0}}};
                        srem_reg <= '0;
                        root_reg <= '0;
                        cnt_reg  <= 6'(ROOT_W - 1);
                    end
                    OP_INNOV:
                    begin
                        innov_reg <= res;
                        acc_reg   <= sx(lp_reg) + sx(growth_reg) + sx(res);
                    end
                    OP_MKT:   acc_reg <= acc_reg + sx(res);
                    OP_SEC:   acc_reg <= acc_reg + sx(res);
                    default: ;
                endcase
            ST_SQRT:
            begin
                rad_reg <= rad_reg << 2;
                cnt_reg <= cnt_reg - 6'd1;
                if (srem_sh >= strial)
                begin
                    srem_reg <= srem_sh - strial;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    srem_reg <= srem_sh;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                end
            end
            ST_EXP:
            begin
                if (lp_reg <= 0)
                    out_word_reg.price <= 31'd1;
                else
                    out_word_reg.price <= PRICE_MAX;
                out_word_reg.log_price_out <= lp_reg;
                xr_reg   <= XR_W'(lp_reg) << (EXP_FRAC - FRAC_BITS);
                k_reg    <= '0;
                cnt_reg  <= 6'd4;
                term_reg <= MUL_AW'(1) << EXP_FRAC;
                esum_reg <= (MUL_AW+1)'(1) << EXP_FRAC;
                n_reg    <= 5'd1;
            end
            ST_KDIV:
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (xr_reg >= ktrial)
                begin
                    xr_reg <= xr_reg - ktrial;
                    k_reg[cnt_reg[2:0]] <= 1'b1;
                end
            end
            ST_TDIV:
            begin
                quo_reg  <= quo_next;
                drem_reg <= drem_next;
                cnt_reg  <= cnt_reg - 6'd1;
                if (cnt_reg == '0)
                begin
                    term_reg <= quo_next[MUL_AW-1:0];
                    esum_reg <= esum_reg + (MUL_AW+1)'(quo_next[MUL_AW-1:0]);
                    n_reg    <= n_reg + 5'd1;
                end
            end
            ST_PFIN:
                out_word_reg.price <= pr_c;
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

FILE: verif/factor_model_price_path_step_test.sv
// Self-checking bench for factor_model_price_path_step: random words through the valid/ready
// ports, register rewrites between phases, scoreboard with a bit-exact path predictor.
// Depends on fmps_pkg and the DUT only.
module factor_model_price_path_step_test;
    import fmps_pkg::*;

    localparam logic [2:0] REG_NONE = 3'd7;

    class path_scoreboard;
        logic [42:0] mkt_load, sec_load;
        logic [40:0] rev_spd;
        logic signed [38:0] growth;
        logic [45:0] start_lp;
        logic signed [47:0] lp, lf, var_q, last_e;
        out_word_t pending[$];
        int errors, checked;

        function void reset_all();
            mkt_load = RST_MKT_LOAD;
            sec_load = RST_SEC_LOAD;
            rev_spd = RST_REV_SPD;
            growth = RST_GROWTH;
            start_lp = RST_START_LP;
            reload();
        endfunction

        function void reload();
            lp = $signed({2'b00, start_lp});
            lf = lp;
            var_q = START_VAR;
            last_e = '0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [45:0] d);
            case (idx)
                REG_MKT_LOAD: mkt_load = d[42:0];
                REG_SEC_LOAD: sec_load = d[42:0];
                REG_REV_SPD: rev_spd = d[40:0];
                REG_GROWTH: growth = d[38:0];
                REG_START_LP: start_lp = d;
                default: ;
            endcase
        endfunction

        function logic signed [47:0] clip(logic signed [63:0] v);
            if (v > 64'sd140737488355327) return MAX48;
            if (v < -64'sd140737488355328) return MIN48;
            return v[47:0];
        endfunction

        function logic signed [47:0] qmul(logic signed [63:0] a, logic signed [63:0] b);
            logic [127:0] p;
            logic [127:0] q;
            logic [127:0] lim;
            logic neg;
            logic signed [63:0] v;
            neg = (a < 0) != (b < 0);
            p = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
            q = (p + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
            lim = neg ? (128'd1 << 47) : 128'(MAX48);
            if (q > lim) q = lim;
            v = neg ? -$signed(q[63:0]) : $signed(q[63:0]);
            return v[47:0];
        endfunction

        function logic [47:0] root(logic signed [47:0] v);
            logic [127:0] x;
            logic [47:0] r;
            logic [47:0] c;
            x = v < 0 ? 128'd0 : (128'(v) << FRAC_BITS);
            r = '0;
            for (int b = 47; b >= 0; b--) begin
                c = r | (48'd1 << b);
                if (128'(c) * 128'(c) <= x) r = c;
            end
            return r;
        endfunction

        function logic [30:0] to_price(logic signed [47:0] x);
            logic [63:0] xg, k, r, t, s, p;
            logic [127:0] w;
            int sh;
            if (x <= 0) return 31'd1;
            if (x >= EXP_HI) return PRICE_MAX;
            xg = 64'(x) << (EXP_FRAC - FRAC_BITS);
            k = xg / 64'(LN2_E);
            r = xg - k * 64'(LN2_E);
            t = 64'd1 << EXP_FRAC;
            s = t;
            for (int n = 1; n <= N_TERMS; n++) begin
                w = 128'(t) * 128'(r);
                t = 64'(w >> EXP_FRAC) / 64'(n);
                s += t;
            end
            sh = EXP_FRAC - int'(k);
            p = (s + (64'd1 << (sh - 1))) >> sh;
            if (p > 64'(PRICE_MAX)) p = 64'(PRICE_MAX);
            if (p < 1) p = 1;
            return p[30:0];
        endfunction

        function void note_input(in_word_t w);
            logic signed [63:0] dev, nx;
            logic signed [47:0] g, innov;
            out_word_t o;
            if (w.path_start) reload();
            dev = 64'(lp) - 64'(lf);
            g = clip(64'(growth) + 64'(w.fundamental_noise));
            lf = clip(64'(lf) + 64'(g));
            var_q = clip(64'(W_OMEGA)
                         + 64'(qmul(64'(W_INNOV), 64'(qmul(64'(last_e), 64'(last_e)))))
                         + 64'(qmul(64'(W_PERSIST), 64'(var_q))));
            innov = qmul(64'(root(var_q)), 64'(w.unit_t_draw));
            nx = 64'(lp) + 64'(g) + 64'(qmul(64'(mkt_load), 64'(w.mkt_return)))
                 + 64'(qmul(64'(sec_load), 64'(w.sector_return)))
                 - 64'(qmul(64'(rev_spd), dev)) + 64'(innov);
            lp = clip(nx);
            last_e = innov;
            o.log_price_out = lp;
            o.price = to_price(lp);
            pending = {pending, o};
        endfunction

        function void check_result(out_word_t got);
            out_word_t e;
            checked++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected word %h", got);
                return;
            end
            e = pending.pop_front();
            if (got.price !== e.price || got.log_price_out !== e.log_price_out) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch #%0d: price exp %0d got %0d, log exp %h got %h",
                             checked, e.price, got.price, e.log_price_out, got.log_price_out);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_word_t in_word = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_word_t out_word;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    path_scoreboard sb;
    int idle_cycles;
    int sent;
    bit long_gaps = 1'b1;

    always #6 clk = ~clk;

    factor_model_price_path_step dut (
        .clk, .rst_n, .in_valid, .in_ready, .in_word,
        .out_valid, .out_ready, .out_word, .cfg_we, .cfg_index, .cfg_data
    );

    function automatic int gap_len();
        if (!long_gaps) return 0;
        if ($urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(20, 700);
    endfunction

    function automatic logic [47:0] rand48();
        case ($urandom_range(0, 5))
            0: return {1'b0, {47{1'b1}}};
            1: return {1'b1, {47{1'b0}}};
            2: return 48'({$urandom, $urandom});
            default: return 48'($signed($urandom_range(0, 8000000)) - 4000000) <<< 20;
        endcase
    endfunction

    task automatic send_word(in_word_t w);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_input(w);
        sent++;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [CFG_W-1:0] d);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        sb.write_reg(idx, d);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic random_word(bit start);
        in_word_t w;
        w.path_start = start;
        w.mkt_return = rand48();
        w.sector_return = rand48();
        w.fundamental_noise = rand48();
        w.unit_t_draw = rand48();
        send_word(w);
    endtask

    always @(posedge clk) begin
        if (out_valid && out_ready) sb.check_result(out_word);
        out_ready <= (!long_gaps || $urandom_range(0, 9) < 6);
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles > 20000) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        in_word_t w;
        sb = new();
        sb.reset_all();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: extremes and path restarts
        w = '0;
        send_word(w);
        w.mkt_return = MAX48; w.sector_return = MAX48;
        w.fundamental_noise = MAX48; w.unit_t_draw = MAX48;
        send_word(w);
        send_word(w);
        w.path_start = 1'b1;
        w.mkt_return = MIN48; w.sector_return = MIN48;
        w.fundamental_noise = MIN48; w.unit_t_draw = MIN48;
        send_word(w);
        w.path_start = 1'b0;
        send_word(w);
        w = '0; w.path_start = 1'b1; w.unit_t_draw = 48'sd1 <<< 42;
        send_word(w);
        for (int i = 0; i < 8; i++) random_word(i[0]);
        drain();
        write_reg(REG_NONE, '1);
        write_reg(REG_MKT_LOAD, 46'd4398046511104);
        write_reg(REG_SEC_LOAD, '0);
        write_reg(REG_REV_SPD, 46'd1099511627776);
        write_reg(REG_GROWTH, 46'(39'sh40_0000_0000));
        write_reg(REG_START_LP, 46'd35184372088832);
        for (int i = 0; i < 6; i++) random_word(i == 0);
        drain();
        for (int ph = 0; ph < 10; ph++) begin
            write_reg(REG_MKT_LOAD, 46'($urandom_range(0, 4096)) << 30);
            write_reg(REG_SEC_LOAD, ph == 9 ? '1 : 46'($urandom_range(0, 4096)) << 30);
            write_reg(REG_REV_SPD, 46'($urandom_range(0, 1024)) << 30);
            write_reg(REG_GROWTH, ph == 3 ? 46'(39'sh3F_FFFF_FFFF) :
                      46'(39'($signed($urandom_range(0, 256)) - 128) <<< 30));
            write_reg(REG_START_LP, ph == 4 ? '0 : 46'($urandom_range(0, 32767)) << 30);
            long_gaps = (ph % 3 != 2);
            for (int i = 0; i < 108; i++) random_word($urandom_range(0, 15) == 0);
            drain();
        end
        long_gaps = 1'b0;
        repeat (50) @(posedge clk);
        $display("Sent %0d words over 12 register settings, %0d results checked.",
                 sent, sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
